[hdl/irt_pkg.sv]
// Shared constants, state type and digit alphabet for the radix text converter.
// No dependencies; imported by integer_to_radix_text.
`default_nettype none

package irt_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_RADIX  = 36;
  localparam int MIN_RADIX  = 2;
  localparam int MIN_ROOM   = 2;

  localparam int NUM_W  = 32;
  localparam int RDX_W  = 6;
  localparam int ROOM_W = 6;
  localparam int CHAR_W = 8;

  localparam int DIG_W  = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int DIG_MAX = VALUE_BITS;
  localparam int CNT_W  = $clog2(DIG_MAX + 1);
  localparam int LEN_W  = ((CNT_W > ROOM_W) ? CNT_W : ROOM_W) + 1;
  localparam int BIT_W  = $clog2(VALUE_BITS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWA  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_SIGN,
    ST_EMIT,
    ST_ERR
  } state_t;

  // Map a digit value to its character in 0-9, a-z.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] w;
    w = CHAR_W'(d);
    if (w < CHAR_W'(10)) begin
      return CHAR_ZERO + w;
    end else begin
      return CHAR_LOWA + w - CHAR_W'(10);
    end
  endfunction

endpackage

`default_nettype wire

[hdl/integer_to_radix_text.sv]
// Signed integer to ASCII text in base 2 to 36, one character per output word.
// Bit-serial restoring divider, digit stack and output register; uses irt_pkg.
// Each request runs one divider pass per digit, a fit check, an optional sign word, then
// the digits. The divider yields one quotient bit per cycle and one digit per pass.
// No new request is taken until the previous one's last word is in the output register.
// Bad requests return their single error word (fit errors after the passes).
// Reset: synchronous, active low; clears the sequencer and the output valid only.
`default_nettype none

module integer_to_radix_text (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [irt_pkg::NUM_W-1:0]  in_number,
  input  wire logic [irt_pkg::RDX_W-1:0]  in_radix,
  input  wire logic [irt_pkg::ROOM_W-1:0] in_room,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [irt_pkg::CHAR_W-1:0]      out_text_char,
  output logic                            out_final_char,
  output logic                            out_bad_request
);
  import irt_pkg::*;

  // Sequencer.
  state_t state_r, state_nxt;

  // Divider: quo_r shifts the dividend out at the top and the quotient in at the bottom.
  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [RDX_W-1:0]      rem_r, rem_nxt;
  logic [BIT_W-1:0]      bit_cnt_r, bit_cnt_nxt;
  logic [RDX_W-1:0]      radix_r, radix_nxt;
  logic [ROOM_W-1:0]     room_r, room_nxt;
  logic                  neg_r, neg_nxt;

  // Digit stack: push at entry 0, pop from entry 0, so the last digit found leaves first.
  logic [DIG_W-1:0] dig_r   [DIG_MAX];
  logic [DIG_W-1:0] dig_nxt [DIG_MAX];
  logic [CNT_W-1:0] ndig_r, ndig_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_final_r, out_final_nxt;
  logic              out_bad_r, out_bad_nxt;

  // Combinational helpers.
  logic                  in_take;
  logic                  out_free;
  logic                  req_bad;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_raw;
  logic [VALUE_BITS-1:0] in_mag;
  logic [RDX_W:0]        trial;
  logic                  trial_ge;
  logic [RDX_W:0]        trial_sub;
  logic                  pass_end;
  logic [LEN_W-1:0]      text_len;
  logic                  fit_bad;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign in_raw  = in_number[VALUE_BITS-1:0];
  assign in_neg  = in_raw[VALUE_BITS-1];
  // The most negative value wraps back to itself: read as unsigned it is 2^(VALUE_BITS-1).
  assign in_mag  = in_neg ? (~in_raw + VALUE_BITS'(1)) : in_raw;
  assign req_bad = (in_radix < RDX_W'(MIN_RADIX)) || (in_radix > RDX_W'(MAX_RADIX)) ||
                   (in_room < ROOM_W'(MIN_ROOM));

  // One restoring division step: bring down the next dividend bit, subtract if it fits.
  assign trial     = {rem_r, quo_r[VALUE_BITS-1]};
  assign trial_ge  = (trial >= {1'b0, radix_r});
  assign trial_sub = trial - {1'b0, radix_r};
  assign pass_end  = (bit_cnt_r == BIT_W'(VALUE_BITS - 1));

  // Sign plus digits plus terminator must fit the room.
  assign text_len = LEN_W'(ndig_r) + LEN_W'(neg_r) + LEN_W'(1);
  assign fit_bad  = (text_len > LEN_W'(room_r));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = req_bad ? ST_ERR : ST_DIV;
        end
      end
      ST_DIV: begin
        if (pass_end && (quo_nxt == '0)) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (fit_bad) begin
          state_nxt = ST_ERR;
        end else if (neg_r) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && (ndig_r == CNT_W'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output word.
  always_comb begin
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    radix_nxt     = radix_r;
    room_nxt      = room_r;
    neg_nxt       = neg_r;
    ndig_nxt      = ndig_r;
    dig_nxt       = dig_r;
    out_char_nxt  = out_char_r;
    out_final_nxt = out_final_r;
    out_bad_nxt   = out_bad_r;
    // Drop the held word once it is taken.
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          quo_nxt     = in_mag;
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
          radix_nxt   = in_radix;
          room_nxt    = in_room;
          neg_nxt     = in_neg;
          ndig_nxt    = '0;
        end
      end
      ST_DIV: begin
        quo_nxt     = {quo_r[VALUE_BITS-2:0], trial_ge};
        rem_nxt     = trial_ge ? trial_sub[RDX_W-1:0] : trial[RDX_W-1:0];
        bit_cnt_nxt = bit_cnt_r + BIT_W'(1);
        if (pass_end) begin
          // Push the remainder as the next digit and start a fresh pass on the quotient.
          for (int i = DIG_MAX - 1; i > 0; i--) begin
            dig_nxt[i] = dig_r[i-1];
          end
          dig_nxt[0]  = rem_nxt[DIG_W-1:0];
          ndig_nxt    = ndig_r + CNT_W'(1);
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
        end
      end
      ST_CHECK: begin
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_final_nxt = 1'b0;
          out_bad_nxt   = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(dig_r[0]);
          out_final_nxt = (ndig_r == CNT_W'(1));
          out_bad_nxt   = 1'b0;
          for (int i = 0; i < DIG_MAX - 1; i++) begin
            dig_nxt[i] = dig_r[i+1];
          end
          ndig_nxt = ndig_r - CNT_W'(1);
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_NUL;
          out_final_nxt = 1'b1;
          out_bad_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    radix_r     <= radix_nxt;
    room_r      <= room_nxt;
    neg_r       <= neg_nxt;
    ndig_r      <= ndig_nxt;
    dig_r       <= dig_nxt;
    out_char_r  <= out_char_nxt;
    out_final_r <= out_final_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_text_char   = out_char_r;
  assign out_final_char  = out_final_r;
  assign out_bad_request = out_bad_r;

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r != ST_IDLE))
    else $error("item taken but sequencer stayed idle");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < radix_r))
    else $error("partial remainder not below radix");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (ndig_r != '0))
    else $error("emitting from an empty digit stack");

  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_request) |-> (out_final_char && (out_text_char == CHAR_NUL)))
    else $error("error word malformed");

  a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SIGN) && out_free) |=> (out_valid && !out_final_char))
    else $error("sign word lost or marked final");
`endif

endmodule

`default_nettype wire

[dv/tb_integer_to_radix_text.sv]
// Self-checking testbench for integer_to_radix_text: directed and random requests,
// with text predicted per accepted request and compared word by word on the output.
// Depends on irt_pkg and the integer_to_radix_text RTL only.

module tb_integer_to_radix_text;
  timeunit 1ns;
  timeprecision 1ps;

  import irt_pkg::*;

  // Cycles without any handshake before the run is declared hung. The slowest
  // conversion (base 2, 32 digits) sits longest in the divider.
  localparam int STUCK_LIMIT = 20000;
  // Settling time after the last awaited word, long enough for a full base-2 pass.
  localparam int TAIL_CYCLES = 1200;
  localparam int RANDOM_ITEMS = 100;
  localparam int REPORT_MAX = 10;
  localparam string DIGIT_SET = "0123456789abcdefghijklmnopqrstuvwxyz";

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              fin;
    logic              bad;
  } text_word_t;

  // Holds the text still owed by the block and checks each output word against it.
  class text_scoreboard;
    text_word_t awaited_text[$];
    int         mismatches;
    int         words_seen;

    function void owe_word(logic [CHAR_W-1:0] ch, logic fin, logic bad);
      text_word_t w;
      w.ch  = ch;
      w.fin = fin;
      w.bad = bad;
      awaited_text.push_back(w);
    endfunction

    // Spell one accepted request into the words it must produce.
    function void spell_number(logic [NUM_W-1:0] number, logic [RDX_W-1:0] radix,
                               logic [ROOM_W-1:0] room);
      logic [NUM_W-1:0] mag;
      logic [NUM_W-1:0] base;
      logic             neg;
      byte unsigned     digits[$];
      int               len;
      if (int'(radix) < MIN_RADIX || int'(radix) > MAX_RADIX || int'(room) < MIN_ROOM) begin
        owe_word(CHAR_NUL, 1'b1, 1'b1);
        return;
      end
      neg  = number[NUM_W-1];
      // Two's complement negation leaves the most negative value as 2^31 unsigned.
      mag  = neg ? -number : number;
      base = NUM_W'(radix);
      do begin
        digits.push_front(DIGIT_SET[mag % base]);
        mag = mag / base;
      end while (mag != '0);
      len = digits.size() + (neg ? 1 : 0);
      // The terminator counts against the room even though it is never sent.
      if (len + 1 > int'(room)) begin
        owe_word(CHAR_NUL, 1'b1, 1'b1);
        return;
      end
      if (neg) begin
        owe_word(CHAR_MINUS, 1'b0, 1'b0);
      end
      foreach (digits[i]) begin
        owe_word(CHAR_W'(digits[i]), (i == digits.size() - 1), 1'b0);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic fin, logic bad);
      text_word_t want;
      if (awaited_text.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: unexpected word: char %h final %b bad %b", $realtime, ch, fin, bad);
        end
        return;
      end
      want = awaited_text.pop_front();
      if (want.ch !== ch || want.fin !== fin || want.bad !== bad) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: word %0d: expected char %h final %b bad %b, got char %h final %b bad %b",
                   $realtime, words_seen, want.ch, want.fin, want.bad, ch, fin, bad);
        end
      end
      words_seen++;
    endfunction

    function int outstanding();
      return awaited_text.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [NUM_W-1:0]   in_number = '0;
  logic [RDX_W-1:0]   in_radix = '0;
  logic [ROOM_W-1:0]  in_room = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  out_text_char;
  logic               out_final_char;
  logic               out_bad_request;

  // Set while both sides run flat out, with no idling and no stalls.
  logic               quiet = 1'b0;
  int                 stuck_cycles = 0;
  text_scoreboard     board = new;

  integer_to_radix_text uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_number       (in_number),
    .in_radix        (in_radix),
    .in_room         (in_room),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_text_char   (out_text_char),
    .out_final_char  (out_final_char),
    .out_bad_request (out_bad_request)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one request, idling first at random, and hold it until the block takes it.
  // The valid is left high on acceptance so that back-to-back requests need no gap.
  task automatic send_request(input logic [NUM_W-1:0] number, input logic [RDX_W-1:0] radix,
                              input logic [ROOM_W-1:0] room);
    while (!quiet && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= number;
    in_radix  <= radix;
    in_room   <= room;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    board.spell_number(number, radix, room);
  endtask

  // Output side: check each accepted word, stall at random, and watch for a hang.
  // Everything here reads the values present at the edge, before any update lands.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_char(out_text_char, out_final_char, out_bad_request);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    out_stall <= !quiet && ($urandom_range(99) < 38);
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, STUCK_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned      pick;
    logic [NUM_W-1:0] number;
    logic [RDX_W-1:0] radix;
    logic [ROOM_W-1:0] room;

    // Hold reset, then release it for good.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: zero, small room, exact fit and one-short fits, the most
    // negative value, the longest texts, every kind of bad base, the top digit.
    send_request(32'd0,          6'd10, 6'd2);
    send_request(32'd0,          6'd10, 6'd1);
    send_request(32'd5,          6'd10, 6'd0);
    send_request(32'hffff_ffff,  6'd10, 6'd3);
    send_request(32'hffff_ffff,  6'd10, 6'd2);
    send_request(32'h8000_0000,  6'd10, 6'd12);
    send_request(32'h8000_0000,  6'd10, 6'd11);
    send_request(32'h7fff_ffff,  6'd2,  6'd32);
    send_request(32'h7fff_ffff,  6'd2,  6'd31);
    send_request(32'h8000_0000,  6'd2,  6'd34);
    send_request(32'h8000_0000,  6'd2,  6'd33);
    send_request(32'h7fff_ffff,  6'd36, 6'd63);
    send_request(32'd35,         6'd36, 6'd2);
    send_request(32'd123,        6'd0,  6'd63);
    send_request(32'd123,        6'd1,  6'd63);
    send_request(32'd123,        6'd37, 6'd63);
    send_request(32'd123,        6'd63, 6'd63);
    send_request(32'hdead_beef,  6'd16, 6'd10);
    send_request(32'hffff_ffff,  6'd63, 6'd0);
    send_request(32'd12345,      6'd8,  6'd63);
    send_request(-32'd36,        6'd36, 6'd4);
    send_request(32'd255,        6'd3,  6'd40);

    // Drop valid and let the block drain completely before the random part.
    in_valid <= 1'b0;
    while (board.outstanding() != 0) begin
      @(posedge clk);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Run a long middle stretch with no idling on either side.
      quiet <= (n >= 40 && n < 80);

      pick = $urandom_range(9);
      if (pick < 5) begin
        number = $urandom;
      end else if (pick < 7) begin
        number = NUM_W'($urandom_range(0, 1000));
      end else if (pick < 8) begin
        number = -NUM_W'($urandom_range(1, 1000));
      end else begin
        number = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      end

      // Mostly legal bases so that real text comes out; the rest anywhere.
      radix = ($urandom_range(99) < 85) ? RDX_W'($urandom_range(MIN_RADIX, MAX_RADIX))
                                        : RDX_W'($urandom_range(63));

      // Room of 34 or more always fits; below that the fit check is exercised.
      pick = $urandom_range(99);
      if (pick < 60) begin
        room = ROOM_W'($urandom_range(34, 63));
      end else if (pick < 85) begin
        room = ROOM_W'($urandom_range(MIN_ROOM, 33));
      end else begin
        room = ROOM_W'($urandom_range(63));
      end

      send_request(number, radix, room);
    end

    // Advance until every owed word has arrived, then give stray words time to show.
    in_valid <= 1'b0;
    while (board.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
